// ===== rtl/hs5_pkg.sv =====
`default_nettype none

package hs5_pkg;

   // value and geometry formats
   localparam int VALUE_BITS  = 24;
   localparam int FRAC_BITS   = 16;
   localparam int COEFF_BITS  = 16;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;

   // datapath widths: signed neighbor sum, product and rounding accumulator
   localparam int SUM_BITS  = VALUE_BITS + 4;
   localparam int PROD_BITS = SUM_BITS + COEFF_BITS + 1;
   localparam int ACC_BITS  = PROD_BITS + 1;

   // register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [REG_IDX_BITS-1:0] REG_GRID_WIDTH      = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_GRID_HEIGHT     = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_COL      = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_ROW      = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_DIFFUSION_COEFF = REG_IDX_BITS'(4);

   // input beat kinds
   localparam logic ACT_CELL  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [VALUE_BITS-1:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] new_value;
      logic [ROW_BITS-1:0]   out_row;
      logic [COL_BITS-1:0]   out_col;
      logic                  frame_last;
   } rsp_type;

   // one column of the row buffers: row r-2 and row r-1
   typedef struct packed {
      logic [VALUE_BITS-1:0] older;
      logic [VALUE_BITS-1:0] prior;
   } row_word_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] cell_value;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic                  last;
      logic                  src;
      logic                  emit;
      logic                  drain;
      logic                  use_up;
      logic                  use_left;
      logic                  use_right;
   } s1_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [VALUE_BITS-1:0]      ctr;
      logic                       src;
      logic [ROW_BITS-1:0]        row;
      logic [COL_BITS-1:0]        col;
      logic                       last;
   } s2_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] prod;
      logic [VALUE_BITS-1:0]       ctr;
      logic                        src;
      logic [ROW_BITS-1:0]         row;
      logic [COL_BITS-1:0]         col;
      logic                        last;
   } s3_type;

endpackage

`default_nettype wire

// ===== rtl/hs5_slot.sv =====
`default_nettype none

// One cell of the pipeline chain: holds a beat and hands it on when the
// next cell takes it. Takes a new beat in the same cycle the held one leaves.
module hs5_slot #(
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [DATA_BITS-1:0] in_data,
   output logic                      in_stall,
   output logic                      out_valid,
   output logic [DATA_BITS-1:0]      out_data,
   input  wire logic                 out_stall
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [DATA_BITS-1:0] data_ff;
   logic                 take;

   // stall upstream only while holding a beat that cannot leave
   assign in_stall  = valid_ff & out_stall;
   assign take      = in_valid & ~in_stall;
   assign valid_in  = take | (valid_ff & out_stall);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load payload on take, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hs5_rowbuf.sv =====
`default_nettype none

// Row buffers for both previous rows, one word per column. One write port,
// two registered read ports. A write and a read of the same column at the
// same edge return the newly written word.
module hs5_rowbuf
   import hs5_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [COL_BITS-1:0] wr_addr,
   input  wire row_word_type        wr_word,
   input  wire logic                rd_en,
   input  wire logic [COL_BITS-1:0] rd_addr_a,
   input  wire logic [COL_BITS-1:0] rd_addr_b,
   output row_word_type             rd_word_a,
   output logic [VALUE_BITS-1:0]    rd_prior_b
);

   row_word_type          mem_ff [MAX_WIDTH];
   row_word_type          rd_a_ff;
   logic [VALUE_BITS-1:0] rd_b_ff;
   row_word_type          fwd_word_ff;
   logic                  fwd_a_ff;
   logic                  fwd_b_ff;

   // write the column that just left the first stage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_word;
      end
   end

   // read both columns; note collisions with the write at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff     <= mem_ff[rd_addr_a];
         rd_b_ff     <= mem_ff[rd_addr_b].prior;
         fwd_word_ff <= wr_word;
         fwd_a_ff    <= wr_en && (wr_addr == rd_addr_a);
         fwd_b_ff    <= wr_en && (wr_addr == rd_addr_b);
      end
   end

   assign rd_word_a  = fwd_a_ff ? fwd_word_ff : rd_a_ff;
   assign rd_prior_b = fwd_b_ff ? fwd_word_ff.prior : rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/heat_stencil_5point_step_top.sv =====
`default_nettype none

// Five-point heat stencil, one Jacobi step on a grid streamed in raster
// order. Old cells enter one per beat and the block sustains one beat per
// clock unless rsp_stall holds it; the row buffers are a single 1024 x 48
// memory with one write port and two read ports (column c and c+1), so no
// item waits on another. A new cell value leaves through the chain cells
// after the beat that completes its neighborhood: row r-1 comes out while
// row r streams in, and after the last row one drain beat per column flushes
// it, the last carrying frame_last. Cells of the first row and beats that
// fall outside the frame give no result. The chain is four cells (buffer
// read and neighbor sum, multiply, round and saturate, output register), so
// a waiting result never blocks the input until the whole chain is full.
// Buffers come up undefined and need no clearing pass; the user must write
// registers over the APB port only while the block is idle (not enforced).
module heat_stencil_5point_step_top
   import hs5_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   // registers
   logic [WIDTH_BITS-1:0]  grid_width_ff;
   logic [HEIGHT_BITS-1:0] grid_height_ff;
   logic [COL_BITS-1:0]    source_col_ff;
   logic [ROW_BITS-1:0]    source_row_ff;
   logic [COEFF_BITS-1:0]  diffusion_coeff_ff;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff      <= WIDTH_BITS'(1024);
         grid_height_ff     <= HEIGHT_BITS'(1024);
         source_col_ff      <= COL_BITS'(256);
         source_row_ff      <= ROW_BITS'(256);
         diffusion_coeff_ff <= COEFF_BITS'(13107);
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_GRID_WIDTH:      grid_width_ff      <= pwdata[WIDTH_BITS-1:0];
            REG_GRID_HEIGHT:     grid_height_ff     <= pwdata[HEIGHT_BITS-1:0];
            REG_SOURCE_COL:      source_col_ff      <= pwdata[COL_BITS-1:0];
            REG_SOURCE_ROW:      source_row_ff      <= pwdata[ROW_BITS-1:0];
            REG_DIFFUSION_COEFF: diffusion_coeff_ff <= pwdata[COEFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GRID_WIDTH:      prdata = CSR_DATA_BITS'(grid_width_ff);
         REG_GRID_HEIGHT:     prdata = CSR_DATA_BITS'(grid_height_ff);
         REG_SOURCE_COL:      prdata = CSR_DATA_BITS'(source_col_ff);
         REG_SOURCE_ROW:      prdata = CSR_DATA_BITS'(source_row_ff);
         REG_DIFFUSION_COEFF: prdata = CSR_DATA_BITS'(diffusion_coeff_ff);
         default:             prdata = '0;
      endcase
   end

   // clamp geometry to 1..max
   logic [WIDTH_BITS-1:0]  eff_w;
   logic [HEIGHT_BITS-1:0] eff_h;

   always_comb begin
      if (grid_width_ff == '0) begin
         eff_w = WIDTH_BITS'(1);
      end else if (grid_width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         eff_w = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         eff_w = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         eff_h = HEIGHT_BITS'(1);
      end else if (grid_height_ff > HEIGHT_BITS'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         eff_h = grid_height_ff;
      end
   end

   // frame counters
   logic [HEIGHT_BITS-1:0] row_cnt_ff, row_cnt_in;
   logic [COL_BITS-1:0]    col_cnt_ff, col_cnt_in;
   logic [COL_BITS-1:0]    drain_cnt_ff, drain_cnt_in;

   logic                   req_accept;
   logic                   enter;
   logic                   frame_end;
   logic                   row_full;
   logic                   col_wrap;
   logic                   drain_wrap;
   logic [HEIGHT_BITS-1:0] row_cur;
   logic [COL_BITS-1:0]    col_cur;
   logic [WIDTH_BITS-1:0]  col_next;
   logic [WIDTH_BITS-1:0]  drain_next;
   s1_type                 s1_in;

   assign req_accept = req_valid & ~req_stall;
   assign row_full   = row_cnt_ff >= eff_h;
   assign col_wrap   = {1'b0, col_cnt_ff} >= eff_w;
   assign drain_wrap = {1'b0, drain_cnt_ff} >= eff_w;
   assign row_cur    = col_wrap ? row_cnt_ff + HEIGHT_BITS'(1) : row_cnt_ff;
   assign col_cur    = col_wrap ? '0 : col_cnt_ff;
   assign col_next   = {1'b0, col_cur} + WIDTH_BITS'(1);
   assign drain_next = {1'b0, drain_cnt_ff} + WIDTH_BITS'(1);

   // place the beat in the frame, decide what it writes and emits
   always_comb begin
      row_cnt_in       = row_cnt_ff;
      col_cnt_in       = col_cnt_ff;
      drain_cnt_in     = drain_cnt_ff;
      enter            = 1'b0;
      frame_end        = 1'b0;
      s1_in.cell_value = req_data.cell_value;
      s1_in.drain      = req_data.action == ACT_DRAIN;
      if (req_data.action == ACT_CELL) begin
         s1_in.row       = ROW_BITS'(row_cur - HEIGHT_BITS'(1));
         s1_in.col       = col_cur;
         s1_in.last      = 1'b0;
         s1_in.emit      = row_cur != '0;
         s1_in.use_up    = row_cur >= HEIGHT_BITS'(2);
         s1_in.use_left  = col_cur != '0;
         s1_in.use_right = col_next < eff_w;
         if (!row_full) begin
            if (col_wrap && (row_cur >= eff_h)) begin
               row_cnt_in = row_cur;
               col_cnt_in = '0;
            end else begin
               enter = 1'b1;
               if (col_next >= eff_w) begin
                  col_cnt_in = '0;
                  row_cnt_in = row_cur + HEIGHT_BITS'(1);
               end else begin
                  col_cnt_in = col_next[COL_BITS-1:0];
                  row_cnt_in = row_cur;
               end
            end
         end
      end else begin
         s1_in.row       = ROW_BITS'(eff_h - HEIGHT_BITS'(1));
         s1_in.col       = drain_cnt_ff;
         s1_in.last      = drain_next == eff_w;
         s1_in.emit      = 1'b1;
         s1_in.use_up    = eff_h > HEIGHT_BITS'(1);
         s1_in.use_left  = drain_cnt_ff != '0;
         s1_in.use_right = drain_next < eff_w;
         if (row_full) begin
            enter = !drain_wrap;
            if (drain_wrap || (drain_next >= eff_w)) begin
               frame_end    = 1'b1;
               row_cnt_in   = '0;
               col_cnt_in   = '0;
               drain_cnt_in = '0;
            end else begin
               drain_cnt_in = drain_next[COL_BITS-1:0];
            end
         end
      end
      s1_in.src = (s1_in.row == source_row_ff) && (s1_in.col == source_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         drain_cnt_ff <= '0;
      end else if (req_accept) begin
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

   // chain cell 1: row buffer read, neighbor gather
   logic         s1_valid, s1_out_stall, s1_fire;
   s1_type       s1_q;
   logic         s2_in_stall, s2_valid;
   s2_type       s2_in, s2_q;
   logic         s3_in_stall, s3_valid;
   s3_type       s3_in, s3_q;
   logic         s4_in_stall;
   rsp_type      s4_in;

   row_word_type          rd_word_a;
   logic [VALUE_BITS-1:0] rd_prior_b;
   row_word_type          wr_word;
   logic [VALUE_BITS-1:0] left_ff;

   hs5_slot #(.DATA_BITS($bits(s1_type))) u_s1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid & enter),
      .in_data   (s1_in),
      .in_stall  (req_stall),
      .out_valid (s1_valid),
      .out_data  (s1_q),
      .out_stall (s1_out_stall)
   );

   hs5_rowbuf u_rowbuf (
      .clock      (clock),
      .wr_en      (s1_fire),
      .wr_addr    (s1_q.col),
      .wr_word    (wr_word),
      .rd_en      (req_accept & enter),
      .rd_addr_a  (s1_in.col),
      .rd_addr_b  (s1_in.col + COL_BITS'(1)),
      .rd_word_a  (rd_word_a),
      .rd_prior_b (rd_prior_b)
   );

   // beats with no result only update the buffers and drop out here
   assign s1_out_stall = s1_q.emit & s2_in_stall;
   assign s1_fire      = s1_valid & ~s1_out_stall;

   logic [VALUE_BITS-1:0] n_ctr, n_up, n_down, n_left, n_right;
   logic [SUM_BITS-1:0]   n_sum;

   always_comb begin
      n_ctr   = rd_word_a.prior;
      n_up    = s1_q.use_up    ? rd_word_a.older : n_ctr;
      n_down  = s1_q.drain     ? n_ctr           : s1_q.cell_value;
      n_left  = s1_q.use_left  ? left_ff         : n_ctr;
      n_right = s1_q.use_right ? rd_prior_b      : n_ctr;
      n_sum   = SUM_BITS'(n_up) + SUM_BITS'(n_down) + SUM_BITS'(n_left)
              + SUM_BITS'(n_right) - (SUM_BITS'(n_ctr) << 2);
      wr_word.older = n_ctr;
      wr_word.prior = n_down;
      s2_in.sum  = $signed(n_sum);
      s2_in.ctr  = n_ctr;
      s2_in.src  = s1_q.src;
      s2_in.row  = s1_q.row;
      s2_in.col  = s1_q.col;
      s2_in.last = s1_q.last;
   end

   // the column just shifted into the older row is the next column's left
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         left_ff <= n_ctr;
      end
   end

   // chain cell 2: multiply by the coefficient
   hs5_slot #(.DATA_BITS($bits(s2_type))) u_s2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid & s1_q.emit),
      .in_data   (s2_in),
      .in_stall  (s2_in_stall),
      .out_valid (s2_valid),
      .out_data  (s2_q),
      .out_stall (s3_in_stall)
   );

   always_comb begin
      s3_in.prod = PROD_BITS'(s2_q.sum * $signed({1'b0, diffusion_coeff_ff}));
      s3_in.ctr  = s2_q.ctr;
      s3_in.src  = s2_q.src;
      s3_in.row  = s2_q.row;
      s3_in.col  = s2_q.col;
      s3_in.last = s2_q.last;
   end

   // chain cell 3: round to nearest and saturate
   hs5_slot #(.DATA_BITS($bits(s3_type))) u_s3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_data   (s3_in),
      .in_stall  (s3_in_stall),
      .out_valid (s3_valid),
      .out_data  (s3_q),
      .out_stall (s4_in_stall)
   );

   logic signed [ACC_BITS-1:0] acc_base, acc_prod, acc;

   always_comb begin
      acc_base = {{(ACC_BITS-VALUE_BITS-FRAC_BITS){1'b0}}, s3_q.ctr, {FRAC_BITS{1'b0}}};
      acc_prod = {{(ACC_BITS-PROD_BITS){s3_q.prod[PROD_BITS-1]}}, s3_q.prod};
      acc      = acc_base + acc_prod + (ACC_BITS'(1) << (FRAC_BITS - 1));
      if (s3_q.src) begin
         s4_in.new_value = s3_q.ctr;
      end else if (acc[ACC_BITS-1]) begin
         s4_in.new_value = '0;
      end else if (|acc[ACC_BITS-2:FRAC_BITS+VALUE_BITS]) begin
         s4_in.new_value = '1;
      end else begin
         s4_in.new_value = acc[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];
      end
      s4_in.out_row    = s3_q.row;
      s4_in.out_col    = s3_q.col;
      s4_in.frame_last = s3_q.last;
   end

   // chain cell 4: output register
   hs5_slot #(.DATA_BITS($bits(rsp_type))) u_s4 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_data   (s4_in),
      .in_stall  (s4_in_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

`ifndef SYNTHESIS
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid)
      else $error("input stalled with first cell empty");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s1_valid && !rsp_valid)
      else $error("chain not empty after reset");

   a_emit_moves_on: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_q.emit) |=> s2_valid)
      else $error("emitting beat lost after buffer stage");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && frame_end) |=>
         row_cnt_ff == '0 && col_cnt_ff == '0 && drain_cnt_ff == '0)
      else $error("counters not cleared at end of frame");
`endif

endmodule

`default_nettype wire
